FILE: rtl/core/offe_pkg.sv
// Package for the octave Fourier feature encoder: register codes, widths and sine table math.
`timescale 1ns / 1ps
`default_nettype none

package offe_pkg;

  localparam int unsigned BaseWidth   = 24;
  localparam int unsigned CountWidth  = 5;
  localparam int unsigned SampleWidth = 24;
  localparam int unsigned ValueWidth  = 16;
  localparam int unsigned MagWidth    = 15;
  localparam int unsigned OctaveWidth = 4;
  localparam int unsigned CfgAddrWidth = 2;
  localparam int unsigned FracBits    = 36;

  localparam logic [BaseWidth-1:0]  BaseReset  = 24'd1048576;
  localparam logic [CountWidth-1:0] CountReset = 5'd8;

  localparam logic [CfgAddrWidth-1:0] CfgBaseFrequency = 2'd0;
  localparam logic [CfgAddrWidth-1:0] CfgFrequencyCount = 2'd1;

  localparam logic [63:0] PiQ60 = 64'h3243F6A8885A308D;
  localparam logic [63:0] MagMax = 64'd32767;

  // (a * b) >> 60 on unsigned Q60 operands, kept to 64 bits
  function automatic logic [63:0] mul_q60(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = 128'(a) * 128'(b);
    return p[123:60];
  endfunction

  // Divide a Taylor term by (n+1)(n+2) for the j-th odd power n = 2j+1
  function automatic logic [63:0] div_term(input logic [63:0] v, input int unsigned j);
    logic [63:0] r;
    case (j)
      0:  r = v / 64'd6;
      1:  r = v / 64'd20;
      2:  r = v / 64'd42;
      3:  r = v / 64'd72;
      4:  r = v / 64'd110;
      5:  r = v / 64'd156;
      6:  r = v / 64'd210;
      7:  r = v / 64'd272;
      8:  r = v / 64'd342;
      9:  r = v / 64'd420;
      10: r = v / 64'd506;
      11: r = v / 64'd600;
      12: r = v / 64'd702;
      13: r = v / 64'd812;
      14: r = v / 64'd930;
      15: r = v / 64'd1056;
      16: r = v / 64'd1190;
      17: r = v / 64'd1332;
      18: r = v / 64'd1482;
      19: r = v / 64'd1640;
      20: r = v / 64'd1806;
      21: r = v / 64'd1980;
      22: r = v / 64'd2162;
      23: r = v / 64'd2352;
      24: r = v / 64'd2550;
      25: r = v / 64'd2756;
      26: r = v / 64'd2970;
      27: r = v / 64'd3192;
      28: r = v / 64'd3422;
      29: r = v / 64'd3660;
      default: r = '0;
    endcase
    return r;
  endfunction

  // round(32767 * sin(2*pi*m / 2^pb)) for 0 <= m <= 2^(pb-2), elaboration only
  function automatic logic [MagWidth-1:0] quarter_sine(input int unsigned m,
                                                       input int unsigned pb);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] pos;
    logic [63:0] neg;
    logic [63:0] s;
    logic [63:0] scaled;
    logic        add;
    int unsigned j;
    x    = (PiQ60 >> (pb - 1)) * 64'(m);
    x2   = mul_q60(x, x);
    term = x;
    pos  = '0;
    neg  = '0;
    add  = 1'b1;
    for (j = 0; j < 30; j++) begin
      if (term != '0) begin
        if (add) pos = pos + term;
        else neg = neg + term;
        add  = !add;
        term = div_term(mul_q60(term, x2), j);
      end
    end
    s      = (pos > neg) ? pos - neg : '0;
    scaled = (s >> 20) * MagMax + (64'd1 << 39);
    scaled = scaled >> 40;
    if (scaled > MagMax) scaled = MagMax;
    return scaled[MagWidth-1:0];
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/octave_fourier_feature_encoder.sv
// Octave Fourier feature encoder: cosine/sine pairs at octave frequencies per sample.
//
// Channel   Dir  Fields (low bit up)                                      Handshake
// s_axis    in   tdata: sample_value[23:0]                                tvalid/tready
// m_axis    out  tdata: octave_index[3:0] cosine[19:4] sine[35:20] pad    tvalid/tready
//                tlast: last_flag
// cfg       in   cfg_addr_i 0 base_frequency, 1 frequency_count            cfg_we_i
//
// Each sample yields frequency_count results (clamped to 1..MAX_FREQUENCIES): the sequencer
// issues one read pair per cycle to the quarter-wave sine RAM while m_axis does not stall.
// A sample's results pass the sequencer, RAM output stage and output register to m_axis.
// After reset the sine RAM is loaded with 2^(PHASE_BITS-2)+1 entries (1025 by default)
// while s_axis_tready stays low; configuration writes are taken throughout.
// When m_axis stalls, the RAM output stage and the output register fill, then the
// sequencer holds and s_axis_tready drops.
`timescale 1ns / 1ps
`default_nettype none

module octave_fourier_feature_encoder
  import offe_pkg::*;
#(
  parameter int unsigned MAX_FREQUENCIES = 16,
  parameter int unsigned PHASE_BITS      = 12
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  // configuration write port
  input  wire logic                    cfg_we_i,
  input  wire logic [CfgAddrWidth-1:0] cfg_addr_i,
  input  wire logic [BaseWidth-1:0]    cfg_wdata_i,
  // input samples
  input  wire logic                    s_axis_tvalid,
  output logic                         s_axis_tready,
  input  wire logic [23:0]             s_axis_tdata,  // sample_value[23:0]
  // results
  output logic                         m_axis_tvalid,
  input  wire logic                    m_axis_tready,
  output logic [39:0]                  m_axis_tdata,  // octave_index, cosine, sine, zeros
  output logic                         m_axis_tlast   // last_flag
);

  localparam int unsigned Quarter = 2 ** (PHASE_BITS - 2);
  localparam int unsigned AW      = PHASE_BITS - 1;
  localparam int unsigned IW      = (MAX_FREQUENCIES > 1) ? $clog2(MAX_FREQUENCIES) : 1;

  typedef logic [MagWidth-1:0] qtab_t [Quarter+1];

  typedef struct packed {
    logic          neg;
    logic [AW-1:0] addr;
  } fold_t;

  function automatic qtab_t build_qtab();
    qtab_t t;
    for (int k = 0; k <= Quarter; k++) begin
      t[k] = quarter_sine(k, PHASE_BITS);
    end
    return t;
  endfunction

  localparam qtab_t QTab = build_qtab();

  // Map a full-period index onto the quarter-wave table and a sign
  function automatic fold_t fold_index(input logic [PHASE_BITS-1:0] idx);
    fold_t         f;
    logic [AW-1:0] r;
    r      = {1'b0, idx[PHASE_BITS-3:0]};
    f.addr = idx[PHASE_BITS-2] ? AW'(Quarter) - r : r;
    f.neg  = idx[PHASE_BITS-1];
    return f;
  endfunction

  // configuration
  logic [BaseWidth-1:0]  base_q;
  logic [CountWidth-1:0] count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q  <= BaseReset;
      count_q <= CountReset;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        CfgBaseFrequency:  base_q  <= cfg_wdata_i;
        CfgFrequencyCount: count_q <= cfg_wdata_i[CountWidth-1:0];
        default: ;
      endcase
    end
  end

  logic [5:0]    count_eff;
  logic [IW-1:0] last_idx;

  always_comb begin
    if (count_q == '0) count_eff = 6'd1;
    else if (6'(count_q) > 6'(MAX_FREQUENCIES)) count_eff = 6'(MAX_FREQUENCIES);
    else count_eff = 6'(count_q);
    last_idx = IW'(count_eff - 6'd1);
  end

  // table load after reset
  logic          fill_active_q;
  logic [AW-1:0] fill_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_active_q <= 1'b1;
      fill_cnt_q    <= '0;
    end else if (fill_active_q) begin
      if (fill_cnt_q == AW'(Quarter)) fill_active_q <= 1'b0;
      else fill_cnt_q <= fill_cnt_q + 1'b1;
    end
  end

  // pipeline control
  logic gen_valid_q;
  logic rd_valid_q;
  logic out_valid_q;
  logic gen_last;
  logic issue;
  logic adv_out;
  logic load;

  logic [FracBits-1:0] ph_q;
  logic [IW-1:0]       i_q;

  assign adv_out       = rd_valid_q && (!out_valid_q || m_axis_tready);
  assign issue         = gen_valid_q && (!rd_valid_q || adv_out);
  assign gen_last      = (i_q == last_idx);
  assign s_axis_tready = !fill_active_q && (!gen_valid_q || (issue && gen_last));
  assign load          = s_axis_tvalid && s_axis_tready;

  // base * sample, only the fractional turns survive the octave shifts
  logic signed [48:0] product;
  assign product = $signed({1'b0, base_q}) * $signed(s_axis_tdata);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gen_valid_q <= 1'b0;
    end else if (load) begin
      gen_valid_q <= 1'b1;
    end else if (issue && gen_last) begin
      gen_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      ph_q <= product[FracBits-1:0];
      i_q  <= '0;
    end else if (issue) begin
      ph_q <= ph_q << 1;
      i_q  <= i_q + 1'b1;
    end
  end

  // table reads
  fold_t sin_fold;
  fold_t cos_fold;
  logic [PHASE_BITS-1:0] sin_idx;
  logic [PHASE_BITS-1:0] cos_idx;

  assign sin_idx  = ph_q[FracBits-1 -: PHASE_BITS];
  assign cos_idx  = sin_idx + PHASE_BITS'(Quarter);
  assign sin_fold = fold_index(sin_idx);
  assign cos_fold = fold_index(cos_idx);

  logic [MagWidth-1:0] sin_mag;
  logic [MagWidth-1:0] cos_mag;

  offe_ram #(
    .WIDTH (MagWidth),
    .DEPTH (Quarter + 1)
  ) u_sine_ram (
    .clk_i     (clk_i),
    .we_i      (fill_active_q),
    .waddr_i   (fill_cnt_q),
    .wdata_i   (QTab[fill_cnt_q]),
    .re_i      (issue),
    .raddr_a_i (sin_fold.addr),
    .raddr_b_i (cos_fold.addr),
    .rdata_a_o (sin_mag),
    .rdata_b_o (cos_mag)
  );

  // RAM output stage sidecar
  logic                   rd_sin_neg_q;
  logic                   rd_cos_neg_q;
  logic [OctaveWidth-1:0] rd_oct_q;
  logic                   rd_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_valid_q <= 1'b0;
    end else if (issue) begin
      rd_valid_q <= 1'b1;
    end else if (adv_out) begin
      rd_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      rd_sin_neg_q <= sin_fold.neg;
      rd_cos_neg_q <= cos_fold.neg;
      rd_oct_q     <= OctaveWidth'(i_q);
      rd_last_q    <= gen_last;
    end
  end

  // output register
  logic signed [ValueWidth-1:0] sin_d;
  logic signed [ValueWidth-1:0] cos_d;
  logic signed [ValueWidth-1:0] sin_q;
  logic signed [ValueWidth-1:0] cos_q;
  logic [OctaveWidth-1:0]       oct_q;
  logic                         last_q;

  assign sin_d = rd_sin_neg_q ? -$signed({1'b0, sin_mag}) : $signed({1'b0, sin_mag});
  assign cos_d = rd_cos_neg_q ? -$signed({1'b0, cos_mag}) : $signed({1'b0, cos_mag});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv_out) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_out) begin
      sin_q  <= sin_d;
      cos_q  <= cos_d;
      oct_q  <= rd_oct_q;
      last_q <= rd_last_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'b0, sin_q, cos_q, oct_q};
  assign m_axis_tlast  = last_q;

`ifndef SYNTHESIS
  a_no_accept_during_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_active_q |-> !s_axis_tready)
    else $error("sample accepted while sine table loads");

  a_no_read_during_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    gen_valid_q |-> !fill_active_q)
    else $error("sequencer active while sine table loads");

  a_index_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    gen_valid_q |-> (i_q <= last_idx))
    else $error("octave index past frequency count");

  a_rd_stage_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rd_valid_q && !adv_out) |=> (rd_valid_q && $stable(rd_oct_q) && $stable(sin_mag)))
    else $error("RAM output stage lost a stalled result");
`endif

endmodule

`default_nettype wire

FILE: rtl/core/offe_ram.sv
// Generic simple dual-port RAM: one write port, two registered read ports.
`timescale 1ns / 1ps
`default_nettype none

module offe_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic      [WIDTH-1:0]         rdata_a_o,
  output logic      [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_a_o <= mem_q[raddr_a_i];
      rdata_b_o <= mem_q[raddr_b_i];
    end
  end

endmodule

`default_nettype wire

FILE: tb/octave_fourier_feature_encoder_tb.sv
// Self-checking testbench for the octave Fourier feature encoder stream and register port.
`timescale 1ns / 1ps

module octave_fourier_feature_encoder_tb;
  import offe_pkg::*;

  localparam int unsigned MaxFrequencies = 16;
  localparam int unsigned PhaseBits      = 12;
  localparam int unsigned TableSize      = 1 << PhaseBits;
  localparam int unsigned CycleLimit     = 300000;
  localparam int unsigned IdlePercent    = 23;

  localparam logic [CfgAddrWidth-1:0] CfgSpare2 = 2'd2;
  localparam logic [CfgAddrWidth-1:0] CfgSpare3 = 2'd3;
  localparam logic [63:0] PiTurnsQ60 = 64'h3243F6A8885A308D;

  typedef struct packed {
    logic [OctaveWidth-1:0]       octave;
    logic signed [ValueWidth-1:0] cosine;
    logic signed [ValueWidth-1:0] sine;
    logic                         last;
  } feature_t;

  typedef enum logic {RowSample, RowWrite} row_kind_e;

  typedef struct packed {
    row_kind_e                    kind;
    logic [CfgAddrWidth-1:0]      addr;
    logic [BaseWidth-1:0]         value;
    logic                         typed;  // first pair's cos/sin given below
    logic signed [ValueWidth-1:0] cos0;
    logic signed [ValueWidth-1:0] sin0;
  } stim_row_t;

  localparam int unsigned NumRows = 23;
  localparam stim_row_t DirectedRows [NumRows] = '{
    '{RowSample, CfgBaseFrequency, 24'h000000, 1'b1, 16'sd32767, 16'sd0},
    '{RowSample, CfgBaseFrequency, 24'h010000, 1'b1, 16'sd32767, 16'sd0},
    '{RowSample, CfgBaseFrequency, 24'h004000, 1'b1, 16'sd0, 16'sd32767},
    '{RowSample, CfgBaseFrequency, 24'hFFC000, 1'b1, 16'sd0, -16'sd32767},
    '{RowSample, CfgBaseFrequency, 24'h7FFFFF, 1'b0, 16'sd0, 16'sd0},
    '{RowSample, CfgBaseFrequency, 24'h800000, 1'b0, 16'sd0, 16'sd0},
    '{RowSample, CfgBaseFrequency, 24'hFFFFFF, 1'b0, 16'sd0, 16'sd0},
    // unknown register indexes must leave the setting alone
    '{RowWrite, CfgSpare2, 24'hFFFFFF, 1'b0, 16'sd0, 16'sd0},
    '{RowWrite, CfgSpare3, 24'h000000, 1'b0, 16'sd0, 16'sd0},
    '{RowSample, CfgBaseFrequency, 24'h004000, 1'b1, 16'sd0, 16'sd32767},
    '{RowWrite, CfgFrequencyCount, 24'h000000, 1'b0, 16'sd0, 16'sd0},
    '{RowSample, CfgBaseFrequency, 24'h123456, 1'b0, 16'sd0, 16'sd0},
    '{RowWrite, CfgFrequencyCount, 24'h00001F, 1'b0, 16'sd0, 16'sd0},
    '{RowSample, CfgBaseFrequency, 24'h000001, 1'b0, 16'sd0, 16'sd0},
    '{RowWrite, CfgBaseFrequency, 24'hFFFFFF, 1'b0, 16'sd0, 16'sd0},
    '{RowSample, CfgBaseFrequency, 24'h7FFFFF, 1'b0, 16'sd0, 16'sd0},
    '{RowSample, CfgBaseFrequency, 24'h800000, 1'b0, 16'sd0, 16'sd0},
    '{RowWrite, CfgBaseFrequency, 24'h000000, 1'b0, 16'sd0, 16'sd0},
    '{RowSample, CfgBaseFrequency, 24'h5A5A5A, 1'b1, 16'sd32767, 16'sd0},
    // upper data bits must be masked off the count
    '{RowWrite, CfgFrequencyCount, 24'hFFFFE1, 1'b0, 16'sd0, 16'sd0},
    '{RowWrite, CfgBaseFrequency, 24'h000001, 1'b0, 16'sd0, 16'sd0},
    '{RowSample, CfgBaseFrequency, 24'h800000, 1'b0, 16'sd0, 16'sd0},
    '{RowSample, CfgBaseFrequency, 24'hA5A5A5, 1'b0, 16'sd0, 16'sd0}
  };

  logic                    clk_i         = 1'b0;
  logic                    rst_ni        = 1'b0;
  logic                    cfg_we_i      = 1'b0;
  logic [CfgAddrWidth-1:0] cfg_addr_i    = '0;
  logic [BaseWidth-1:0]    cfg_wdata_i   = '0;
  logic                    s_axis_tvalid = 1'b0;
  logic                    s_axis_tready;
  logic [23:0]             s_axis_tdata  = '0;  // sample_value[23:0]
  logic                    m_axis_tvalid;
  logic                    m_axis_tready = 1'b0;
  logic [39:0]             m_axis_tdata;  // octave_index[3:0] cosine[19:4] sine[35:20] zeros
  logic                    m_axis_tlast;  // last_flag

  logic signed [ValueWidth-1:0] sine_lut [TableSize];
  logic [BaseWidth-1:0]         base_setting;
  logic [CountWidth-1:0]        count_setting;
  feature_t                     pending_features [$];
  bit                           steady_window = 1'b0;
  int unsigned                  error_count = 0;
  int unsigned                  samples_sent = 0;
  int unsigned                  features_seen = 0;
  int unsigned                  writes_done = 0;
  int unsigned                  cycle_count = 0;

  octave_fourier_feature_encoder #(
    .MAX_FREQUENCIES(MaxFrequencies),
    .PHASE_BITS     (PhaseBits)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Q60 fixed-point product, upper part kept to 64 bits
  function automatic logic [63:0] q60_product(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] full;
    full = {64'd0, a} * {64'd0, b};
    return full[123:60];
  endfunction

  // Taylor series sine on the first quarter wave, scaled to Q1.15 and rounded
  function automatic logic signed [ValueWidth-1:0] quarter_wave(input int unsigned m);
    logic [63:0] angle;
    logic [63:0] angle_sq;
    logic [63:0] term;
    logic [63:0] pos_sum;
    logic [63:0] neg_sum;
    logic [63:0] diff;
    logic [63:0] scaled;
    int unsigned n;
    bit          plus;
    angle    = (PiTurnsQ60 >> (PhaseBits - 1)) * 64'(m);
    angle_sq = q60_product(angle, angle);
    term     = angle;
    pos_sum  = '0;
    neg_sum  = '0;
    plus     = 1'b1;
    n        = 1;
    while (term != '0 && n < 60) begin
      if (plus) pos_sum = pos_sum + term;
      else neg_sum = neg_sum + term;
      plus = !plus;
      term = q60_product(term, angle_sq) / 64'((n + 1) * (n + 2));
      n    = n + 2;
    end
    diff   = (pos_sum > neg_sum) ? pos_sum - neg_sum : '0;
    scaled = ((diff >> 20) * 64'd32767 + (64'd1 << 39)) >> 40;
    if (scaled > 64'd32767) scaled = 64'd32767;
    return scaled[ValueWidth-1:0];
  endfunction

  initial begin : build_sine_lut
    int unsigned quadrant;
    int unsigned offset;
    logic signed [ValueWidth-1:0] mag;
    for (int unsigned k = 0; k < TableSize; k++) begin
      quadrant = k >> (PhaseBits - 2);
      offset   = k & ((TableSize >> 2) - 1);
      mag      = quarter_wave((quadrant & 1) ? (TableSize >> 2) - offset : offset);
      sine_lut[k] = (quadrant & 2) ? -mag : mag;
    end
  end

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch on %s at result %0d: got %0d, expected %0d",
             what, features_seen, got, want);
    error_count++;
  endtask

  // Work out every cos/sin pair one sample produces under the current settings
  task automatic encode_sample(input logic [SampleWidth-1:0] sample, input logic typed,
                               input logic signed [ValueWidth-1:0] cos0,
                               input logic signed [ValueWidth-1:0] sin0);
    logic [63:0]          product;
    logic [63:0]          phase;
    logic [PhaseBits-1:0] turn_idx;
    logic [PhaseBits-1:0] cos_idx;
    int unsigned          n_out;
    feature_t             f;
    product = {{40{sample[SampleWidth-1]}}, sample} * {40'd0, base_setting};
    n_out   = (count_setting == 0) ? 1 :
              (count_setting > MaxFrequencies) ? MaxFrequencies : count_setting;
    for (int unsigned i = 0; i < n_out; i++) begin
      phase    = product << i;
      turn_idx = phase[FracBits-1 -: PhaseBits];
      cos_idx  = turn_idx + PhaseBits'(TableSize >> 2);
      f.octave = OctaveWidth'(i);
      f.cosine = sine_lut[cos_idx];
      f.sine   = sine_lut[turn_idx];
      f.last   = (i + 1 == n_out);
      if (typed && i == 0) begin
        f.cosine = cos0;
        f.sine   = sin0;
      end
      pending_features = {pending_features, f};
    end
  endtask

  task automatic check_feature();
    feature_t want;
    if (pending_features.size() == 0) begin
      report_mismatch("unexpected result tdata", m_axis_tdata, -1);
      return;
    end
    want = pending_features.pop_front();
    if (m_axis_tdata[3:0] != want.octave)
      report_mismatch("octave_index", m_axis_tdata[3:0], want.octave);
    if ($signed(m_axis_tdata[19:4]) != want.cosine)
      report_mismatch("cosine_value", $signed(m_axis_tdata[19:4]), want.cosine);
    if ($signed(m_axis_tdata[35:20]) != want.sine)
      report_mismatch("sine_value", $signed(m_axis_tdata[35:20]), want.sine);
    if (m_axis_tlast != want.last)
      report_mismatch("last_flag", m_axis_tlast, want.last);
    if (m_axis_tdata[39:36] != '0)
      report_mismatch("tdata padding", m_axis_tdata[39:36], 0);
    features_seen++;
  endtask

  // Result side: check each transaction, then pick the next ready level
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) check_feature();
    m_axis_tready <= steady_window || ($urandom_range(0, 99) >= IdlePercent);
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, pending_features.size());
      $display("FAIL");
      $finish;
    end
  end

  // Leaves valid high on return; the next call or hold_input drives it this same step
  task automatic send_sample(input logic [SampleWidth-1:0] sample, input logic typed,
                             input logic signed [ValueWidth-1:0] cos0,
                             input logic signed [ValueWidth-1:0] sin0);
    while (!steady_window && $urandom_range(0, 99) < IdlePercent) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= sample;
    do @(posedge clk_i); while (!s_axis_tready);
    encode_sample(sample, typed, cos0, sin0);
    samples_sent++;
  endtask

  task automatic hold_input();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic drain_results();
    hold_input();
    while (pending_features.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_register(input logic [CfgAddrWidth-1:0] addr,
                                input logic [BaseWidth-1:0] value);
    drain_results();
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= addr;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (addr == CfgBaseFrequency) base_setting = value;
    else if (addr == CfgFrequencyCount) count_setting = value[CountWidth-1:0];
    writes_done++;
    @(posedge clk_i);
  endtask

  function automatic logic [SampleWidth-1:0] pick_sample();
    logic [SampleWidth-1:0] corners [4];
    corners = '{24'h7FFFFF, 24'h800000, 24'h000000, 24'hFFFFFF};
    if ($urandom_range(0, 9) == 0) return corners[$urandom_range(0, 3)];
    return SampleWidth'($urandom());
  endfunction

  initial begin : stimulus
    logic [BaseWidth-1:0] base_pick;
    logic [BaseWidth-1:0] count_pick;
    base_setting  = BaseReset;
    count_setting = CountReset;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int r = 0; r < NumRows; r++) begin
      if (DirectedRows[r].kind == RowWrite) begin
        write_register(DirectedRows[r].addr, DirectedRows[r].value);
      end else begin
        send_sample(DirectedRows[r].value, DirectedRows[r].typed,
                    DirectedRows[r].cos0, DirectedRows[r].sin0);
      end
    end

    for (int phase_no = 0; phase_no < 4; phase_no++) begin
      case (phase_no)
        0: begin
          base_pick  = BaseWidth'($urandom());
          count_pick = {19'($urandom()), 5'($urandom_range(1, MaxFrequencies))};
        end
        1: begin
          base_pick  = 24'hFFFFFF;
          count_pick = 24'h00001F;
        end
        2: begin
          base_pick  = BaseWidth'($urandom_range(0, 255));
          count_pick = 24'h000000;
        end
        default: begin
          base_pick  = BaseWidth'($urandom());
          count_pick = {19'($urandom()), 5'($urandom_range(0, 31))};
        end
      endcase
      write_register(CfgBaseFrequency, base_pick);
      write_register(CfgFrequencyCount, count_pick);
      steady_window = (phase_no == 1);
      for (int n = 0; n < 26; n++) begin
        // pause the sender until the block has emptied once
        if (phase_no == 0 && n == 15) drain_results();
        send_sample(pick_sample(), 1'b0, '0, '0);
      end
      steady_window = 1'b0;
    end

    drain_results();
    repeat (3 * MaxFrequencies) @(posedge clk_i);
    if (pending_features.size() != 0)
      report_mismatch("results never delivered", 0, pending_features.size());
    $display("encoded %0d samples into %0d checked cos/sin pairs over %0d register writes",
             samples_sent, features_seen, writes_done);
    $display("bases zero to full scale, counts zero through 31, samples at both extremes");
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
